### sv/apcc_pkg.sv
// Package for the action pair conflict classifier: payload types, codes and helpers.
package apcc_pkg;

    localparam int VERTEX_ID_BITS = 16;
    localparam int VertexCmpBits  = (VERTEX_ID_BITS < 16) ? VERTEX_ID_BITS : 16;
    localparam logic [15:0] VERTEX_MASK = 16'((32'd1 << VertexCmpBits) - 32'd1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic             REG_IDX_SLACK = 1'b0;
    localparam logic [15:0]      SLACK_RESET   = 16'd256;

    localparam logic [2:0] CK_NONE          = 3'd0;
    localparam logic [2:0] CK_ARRIVE_TOGETHER = 3'd1;
    localparam logic [2:0] CK_MOVE_ONTO_WAIT  = 3'd2;
    localparam logic [2:0] CK_BOTH_WAIT       = 3'd3;
    localparam logic [2:0] CK_SWAP            = 3'd4;
    localparam logic [2:0] CK_FOLLOW          = 3'd5;

    typedef logic [30:0] time_t;
    typedef logic [31:0] end_time_t;
    typedef logic [32:0] window_t;
    typedef logic [15:0] vertex_t;
    typedef logic [7:0]  agent_t;

    typedef struct packed {
        agent_t  first_agent;
        time_t   first_start;
        time_t   first_duration;
        vertex_t first_from_vertex;
        vertex_t first_to_vertex;
        logic    first_is_wait;
        agent_t  second_agent;
        time_t   second_start;
        time_t   second_duration;
        vertex_t second_from_vertex;
        vertex_t second_to_vertex;
        logic    second_is_wait;
    } pair_in_t;

    typedef struct packed {
        logic [2:0] conflict_kind;
        window_t    window_start;
        window_t    window_end;
        vertex_t    place_from;
        vertex_t    place_to;
        agent_t     agent_a;
        agent_t     agent_b;
    } conflict_out_t;

    // action ends registered after the first stage
    typedef struct packed {
        agent_t    ag1;
        time_t     s1;
        end_time_t e1;
        vertex_t   f1;
        vertex_t   t1;
        logic      w1;
        agent_t    ag2;
        time_t     s2;
        end_time_t e2;
        vertex_t   f2;
        vertex_t   t2;
        logic      w2;
    } pair_calc_t;

    function automatic vertex_t vmask(input vertex_t v);
        return v & VERTEX_MASK;
    endfunction

endpackage

### sv/action_pair_conflict_classifier.sv
// Top level of the action pair conflict classifier: pipeline, slack register, assertions.
//
// Usage:
//   in_valid/in_ready carry one pair of timed actions per transaction (in_data).
//   out_valid/out_ready carry one classification per transaction (out_data).
//   The APB port holds vertex_dwell_slack at byte address 0; pready is always high.
// Pipeline: an accepted pair passes through the input register, the action end adders into
//   the calc register, and compare and select into the result register.
// Throughput: one pair per cycle unless stalled; each of the three stages holds one transaction.
// Stall: when out_valid is high and out_ready is low the result register holds; earlier stages keep
//   filling until all three are occupied, then in_ready falls.
// Reset: all stages empty, vertex_dwell_slack returns to 256 (1.0 in Q8.8).
// Configure only while no transaction is in flight.
module action_pair_conflict_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [apcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [apcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [apcc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  apcc_pkg::pair_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output apcc_pkg::conflict_out_t        out_data
);
    import apcc_pkg::*;

    logic [15:0]   slack_reg;
    pair_in_t      in_reg;
    logic          v1_reg;
    pair_calc_t    calc_reg;
    pair_calc_t    calc_next;
    logic          v2_reg;
    conflict_out_t out_reg;
    conflict_out_t out_next;
    logic          out_valid_reg;

    logic load1;
    logic load2;
    logic load3;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_IDX_SLACK) ? {16'd0, slack_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slack_reg <= SLACK_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_IDX_SLACK)
        begin
            slack_reg <= pwdata[15:0];
        end
    end

    // pipeline flow control
    assign load3    = !out_valid_reg || out_ready;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= in_valid;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1 && in_valid)
        begin
            in_reg <= in_data;
        end
        if (load2 && v1_reg)
        begin
            calc_reg <= calc_next;
        end
        if (load3 && v2_reg)
        begin
            out_reg <= out_next;
        end
    end

    // stage 2: action end times, masked vertex ids
    always_comb
    begin
        calc_next.ag1 = in_reg.first_agent;
        calc_next.s1  = in_reg.first_start;
        calc_next.e1  = {1'b0, in_reg.first_start} + {1'b0, in_reg.first_duration};
        calc_next.f1  = vmask(in_reg.first_from_vertex);
        calc_next.t1  = vmask(in_reg.first_to_vertex);
        calc_next.w1  = in_reg.first_is_wait;
        calc_next.ag2 = in_reg.second_agent;
        calc_next.s2  = in_reg.second_start;
        calc_next.e2  = {1'b0, in_reg.second_start} + {1'b0, in_reg.second_duration};
        calc_next.f2  = vmask(in_reg.second_from_vertex);
        calc_next.t2  = vmask(in_reg.second_to_vertex);
        calc_next.w2  = in_reg.second_is_wait;
    end

    // stage 3: overlap gate and ordered classification
    window_t   sl;
    window_t   s1x;
    window_t   s2x;
    window_t   e1x;
    window_t   e2x;
    window_t   e1sl;
    window_t   e2sl;
    window_t   s2sl;
    window_t   maxs;
    window_t   mine;
    window_t   mine_sl;
    logic      gate;
    logic      same;
    logic      two_onto_one;
    logic      one_onto_two;
    logic      swap_hit;
    logic      follow_hit;

    always_comb
    begin
        sl      = {17'd0, slack_reg};
        s1x     = {2'b00, calc_reg.s1};
        s2x     = {2'b00, calc_reg.s2};
        e1x     = {1'b0, calc_reg.e1};
        e2x     = {1'b0, calc_reg.e2};
        e1sl    = e1x + sl;
        e2sl    = e2x + sl;
        s2sl    = s2x + sl;
        maxs    = (s1x > s2x) ? s1x : s2x;
        mine    = (e1x < e2x) ? e1x : e2x;
        mine_sl = (e1x < e2x) ? e1sl : e2sl;
        gate    = maxs <= mine_sl;

        same         = (calc_reg.t1 == calc_reg.t2) && (e1x <= e2sl) && (e2x <= e1sl);
        two_onto_one = (calc_reg.t2 == calc_reg.f1) && calc_reg.w1
                       && (e2sl >= s1x) && (e2x <= e1sl);
        one_onto_two = (calc_reg.t1 == calc_reg.f2) && calc_reg.w2
                       && (e1sl >= s2x) && (e1x <= e2sl);
        swap_hit     = (calc_reg.f1 == calc_reg.t2) && (calc_reg.f2 == calc_reg.t1)
                       && (calc_reg.f1 != calc_reg.f2) && (maxs <= mine);
        follow_hit   = (calc_reg.t1 == calc_reg.f2) && (e1x <= s2sl) && (s2x <= e1sl);

        out_next.conflict_kind = CK_NONE;
        out_next.window_start  = '0;
        out_next.window_end    = '0;
        out_next.place_from    = '0;
        out_next.place_to      = '0;
        out_next.agent_a       = calc_reg.ag1;
        out_next.agent_b       = calc_reg.ag2;

        if (gate)
        begin
            priority if (same || two_onto_one || one_onto_two)
            begin
                out_next.window_end = mine_sl;
                out_next.place_from = calc_reg.t1;
                out_next.place_to   = calc_reg.t1;
                priority if (same && !calc_reg.w1 && !calc_reg.w2)
                begin
                    out_next.conflict_kind = CK_ARRIVE_TOGETHER;
                    out_next.window_start  = (e1x > e2x) ? e1x : e2x;
                end
                else if (calc_reg.w1 != calc_reg.w2)
                begin
                    out_next.conflict_kind = CK_MOVE_ONTO_WAIT;
                    if (calc_reg.w1)
                    begin
                        out_next.window_start = (e2x > s1x) ? e2x : s1x;
                    end
                    else
                    begin
                        out_next.window_start = (e1x > s2x) ? e1x : s2x;
                    end
                end
                else
                begin
                    out_next.conflict_kind = CK_BOTH_WAIT;
                    out_next.window_start  = maxs;
                end
            end
            else if (swap_hit)
            begin
                out_next.conflict_kind = CK_SWAP;
                out_next.window_start  = maxs;
                out_next.window_end    = mine;
                out_next.place_from    = calc_reg.f1;
                out_next.place_to      = calc_reg.t1;
            end
            else if (follow_hit)
            begin
                out_next.conflict_kind = CK_FOLLOW;
                out_next.window_start  = maxs;
                out_next.window_end    = mine_sl;
                out_next.place_from    = calc_reg.f2;
                out_next.place_to      = calc_reg.f2;
            end
            else
            begin
                out_next.conflict_kind = CK_NONE;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_no_conflict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.conflict_kind == CK_NONE)
        |-> (out_data.window_start == '0 && out_data.window_end == '0
             && out_data.place_from == '0 && out_data.place_to == '0))
        else $error("no-conflict result carries nonzero window or place");

    a_swap_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.conflict_kind == CK_SWAP)
        |-> (out_data.window_start <= out_data.window_end))
        else $error("swap window inverted");

    a_arrive_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.conflict_kind == CK_ARRIVE_TOGETHER)
        |-> (out_data.window_start <= out_data.window_end
             && out_data.place_from == out_data.place_to))
        else $error("arrive-together result malformed");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted transaction lost at input register");
`endif

endmodule
